// ===== rtl/core/ircal_pkg.sv =====
// Shared types and constants for the IR min/max calibrate and normalize block.
// Used by ircal_div and ir_minmax_calibrate_normalize_top; no dependencies.
package ircal_pkg;

   localparam int CHANNELS  = 4;
   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DATA_W    = 10;
   localparam int CHAN_W    = 2;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int DIVISOR_W = DATA_W + 1;
   localparam int DIV_STEPS = DATA_W;
   localparam int STEP_W    = $clog2(DIV_STEPS + 1);

   localparam logic [DATA_W-1:0] FULL_SCALE     = 10'd1023;
   localparam logic [DATA_W-1:0] FAULT_LOW_RST  = 10'd100;
   localparam logic [DATA_W-1:0] FAULT_HIGH_RST = 10'd900;

   typedef logic [DATA_W-1:0] sample_type;

   typedef enum logic {
      OP_CALIBRATE = 1'b0,
      OP_NORMALIZE = 1'b1
   } op_type;

   typedef enum logic {
      REG_FAULT_LOW  = 1'b0,
      REG_FAULT_HIGH = 1'b1
   } reg_index_type;

endpackage

// ===== rtl/core/ircal_div.sv =====
// Bit-serial restoring divider: (diff * 1023) / divisor, one quotient bit per cycle.
// Depends on ircal_pkg. Quotient is known to stay below 1024.
module ircal_div import ircal_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  sample_type           diff,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output sample_type           quotient
);

   logic [PROD_W-1:0]    numer;
   logic [DIVISOR_W-1:0] trial;
   logic                 ge;

   sample_type           rem_ff, rem_in;
   sample_type           num_ff, num_in;
   sample_type           quo_ff, quo_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   // diff * 1023 as (diff << 10) - diff
   assign numer = {diff, {DATA_W{1'b0}}} - {{DATA_W{1'b0}}, diff};
   assign trial = {rem_ff, num_ff[DATA_W-1]};
   assign ge    = (trial >= div_ff);

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // upper half is already below the divisor since the quotient fits DATA_W bits
         rem_in  = numer[PROD_W-1:DATA_W];
         num_in  = numer[DATA_W-1:0];
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = DATA_W'(trial - div_ff);
         end else begin
            rem_in = trial[DATA_W-1:0];
         end
         num_in = {num_ff[DATA_W-2:0], 1'b0};
         quo_in = {quo_ff[DATA_W-2:0], ge};
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/ir_minmax_calibrate_normalize_top.sv =====
// Top level: per-channel min/max calibration and normalization of IR samples.
// Depends on ircal_pkg and ircal_div.
// Path: calibrate and uncalibrated results go through S_PREP and S_DONE; normalize
// goes through S_PREP, S_START, S_DIV (the 10-step serial divider) and S_DONE.
// One item in flight: requests are taken only in S_IDLE, after S_DONE passes the result on.
// Reset (synchronous): ranges to min 1023 / max 0, fault limits to 100 / 900.
module ir_minmax_calibrate_normalize_top import ircal_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] sample
   input  logic [2:0]  req_tuser,   // [0] operation, [2:1] channel
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] value
   output logic [1:0]  rsp_tuser,   // [0] out_of_limits, [1] uncalibrated
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [9:0]  csr_data
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_PREP  = 5'b00010,
      S_START = 5'b00100,
      S_DIV   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type     state_ff, state_in;

   op_type        op_ff, op_in;
   logic [CHAN_W-1:0] ch_ff, ch_in;
   sample_type    smp_ff, smp_in;

   sample_type    range_min_ff [CHANNELS];
   sample_type    range_max_ff [CHANNELS];
   sample_type    fault_low_ff, fault_high_ff;

   sample_type           diff_ff, diff_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;

   sample_type    res_value_ff, res_value_in;
   logic          res_flag_ff, res_flag_in;
   logic          res_uncal_ff, res_uncal_in;

   logic          rsp_valid_ff, rsp_valid_in;
   sample_type    rsp_value_ff, rsp_value_in;
   logic          rsp_flag_ff, rsp_flag_in;
   logic          rsp_uncal_ff, rsp_uncal_in;

   logic [CH_IDX_W-1:0] ch_idx;
   logic          ch_ok;
   sample_type    lo, hi, clamped;
   logic          cal_write;
   logic          req_fire;
   logic          div_start;
   logic          div_done;
   sample_type    quotient;

   assign req_fire = req_tvalid && req_tready;
   assign ch_idx   = CH_IDX_W'(ch_ff);
   assign ch_ok    = (32'(ch_ff) < CHANNELS);
   assign lo       = range_min_ff[ch_idx];
   assign hi       = range_max_ff[ch_idx];

   always_comb begin
      if (smp_ff < lo) begin
         clamped = lo;
      end else if (smp_ff > hi) begin
         clamped = hi;
      end else begin
         clamped = smp_ff;
      end
   end

   assign cal_write = (state_ff == S_PREP) && (op_ff == OP_CALIBRATE) && ch_ok;
   assign div_start = (state_ff == S_START);

   ircal_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .diff     (diff_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      smp_in       = smp_ff;
      diff_in      = diff_ff;
      divisor_in   = divisor_ff;
      res_value_in = res_value_ff;
      res_flag_in  = res_flag_ff;
      res_uncal_in = res_uncal_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_uncal_in = rsp_uncal_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = op_type'(req_tuser[0]);
               ch_in    = req_tuser[2:1];
               smp_in   = req_tdata[DATA_W-1:0];
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            res_flag_in = 1'b0;
            priority if (op_ff == OP_CALIBRATE) begin
               res_value_in = smp_ff;
               res_uncal_in = 1'b0;
               state_in     = S_DONE;
            end else if (!ch_ok || (hi < lo)) begin
               res_value_in = '0;
               res_uncal_in = 1'b1;
               state_in     = S_DONE;
            end else begin
               res_uncal_in = 1'b0;
               diff_in      = clamped - lo;
               divisor_in   = {1'b0, hi} - {1'b0, lo} + DIVISOR_W'(1);
               state_in     = S_START;
            end
         end
         S_START: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               res_value_in = quotient;
               res_flag_in  = (quotient < fault_low_ff) || (quotient > fault_high_ff);
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_flag_in  = res_flag_ff;
               rsp_uncal_in = res_uncal_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fault_low_ff  <= FAULT_LOW_RST;
         fault_high_ff <= FAULT_HIGH_RST;
         for (int i = 0; i < CHANNELS; i++) begin
            range_min_ff[i] <= FULL_SCALE;
            range_max_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (reg_index_type'(csr_index))
               REG_FAULT_LOW:  fault_low_ff  <= csr_data;
               REG_FAULT_HIGH: fault_high_ff <= csr_data;
               default: ;
            endcase
         end
         if (cal_write) begin
            if (smp_ff < lo) begin
               range_min_ff[ch_idx] <= smp_ff;
            end
            if (smp_ff > hi) begin
               range_max_ff[ch_idx] <= smp_ff;
            end
         end
      end
      op_ff        <= op_in;
      ch_ff        <= ch_in;
      smp_ff       <= smp_in;
      diff_ff      <= diff_in;
      divisor_ff   <= divisor_in;
      res_value_ff <= res_value_in;
      res_flag_ff  <= res_flag_in;
      res_uncal_ff <= res_uncal_in;
      rsp_value_ff <= rsp_value_in;
      rsp_flag_ff  <= rsp_flag_in;
      rsp_uncal_ff <= rsp_uncal_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - DATA_W){1'b0}}, rsp_value_ff};
   assign rsp_tuser  = {rsp_uncal_ff, rsp_flag_ff};

endmodule

// ===== test/tb_ir_minmax_calibrate_normalize_top.sv =====
// Self-checking bench for ir_minmax_calibrate_normalize_top: a directed table, then
// random calibrate/normalize streams under several fault-limit settings.
// Depends on ircal_pkg and the RTL of the top level.
`timescale 1ns / 100ps

module tb_ir_minmax_calibrate_normalize_top;
   import ircal_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE       = 20;
   localparam int N_DIRECTED   = 25;
   localparam int N_PHASES     = 5;
   localparam int PHASE_ITEMS  = 80;

   typedef struct packed {
      sample_type value;
      logic       out_of_limits;
      logic       uncalibrated;
   } reading_type;

   typedef struct packed {
      op_type      op;
      logic [1:0]  ch;
      sample_type  s;
      logic        fixed;        // 1: expected reading typed in below
      reading_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [9:0] sample
   logic [2:0]  req_tuser = '0;   // [0] operation, [2:1] channel
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [9:0] value
   logic [1:0]  rsp_tuser;        // [0] out_of_limits, [1] uncalibrated
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [9:0]  csr_data = '0;

   ir_minmax_calibrate_normalize_top uut (.*);

   // bench copy of the block's state
   int unsigned learned_min [CHANNELS];
   int unsigned learned_max [CHANNELS];
   int unsigned limit_low  = 100;
   int unsigned limit_high = 900;

   reading_type readings_due [$];
   int       fail_count = 0;
   int       checked = 0;
   int       n_cal = 0, n_norm = 0, n_flagged = 0, n_uncal = 0;
   int       cycle_count = 0;
   int       burst_left = 0;
   int       gap_max = 0;
   int       rx_tick = 0;

   dir_row_type directed_rows [N_DIRECTED] = '{
      '{OP_NORMALIZE, 2'd0, 10'd0,    1'b1, '{10'd0,    1'b0, 1'b1}},
      '{OP_NORMALIZE, 2'd1, 10'd1023, 1'b1, '{10'd0,    1'b0, 1'b1}},
      '{OP_CALIBRATE, 2'd0, 10'd0,    1'b1, '{10'd0,    1'b0, 1'b0}},
      '{OP_CALIBRATE, 2'd0, 10'd1023, 1'b1, '{10'd1023, 1'b0, 1'b0}},
      '{OP_NORMALIZE, 2'd0, 10'd1023, 1'b1, '{10'd1022, 1'b1, 1'b0}},
      '{OP_NORMALIZE, 2'd0, 10'd0,    1'b1, '{10'd0,    1'b1, 1'b0}},
      '{OP_NORMALIZE, 2'd0, 10'd512,  1'b1, '{10'd511,  1'b0, 1'b0}},
      // just either side of the default limits
      '{OP_NORMALIZE, 2'd0, 10'd100,  1'b1, '{10'd99,   1'b1, 1'b0}},
      '{OP_NORMALIZE, 2'd0, 10'd101,  1'b1, '{10'd100,  1'b0, 1'b0}},
      '{OP_NORMALIZE, 2'd0, 10'd901,  1'b1, '{10'd900,  1'b0, 1'b0}},
      '{OP_NORMALIZE, 2'd0, 10'd902,  1'b1, '{10'd901,  1'b1, 1'b0}},
      // single-point range, samples clamped from both sides
      '{OP_CALIBRATE, 2'd1, 10'd500,  1'b1, '{10'd500,  1'b0, 1'b0}},
      '{OP_NORMALIZE, 2'd1, 10'd500,  1'b0, '0},
      '{OP_NORMALIZE, 2'd1, 10'd0,    1'b0, '0},
      '{OP_NORMALIZE, 2'd1, 10'd1023, 1'b0, '0},
      '{OP_CALIBRATE, 2'd2, 10'd300,  1'b1, '{10'd300,  1'b0, 1'b0}},
      '{OP_CALIBRATE, 2'd2, 10'd700,  1'b1, '{10'd700,  1'b0, 1'b0}},
      '{OP_NORMALIZE, 2'd2, 10'd250,  1'b0, '0},
      '{OP_NORMALIZE, 2'd2, 10'd500,  1'b0, '0},
      '{OP_NORMALIZE, 2'd2, 10'd800,  1'b0, '0},
      '{OP_CALIBRATE, 2'd3, 10'd1023, 1'b1, '{10'd1023, 1'b0, 1'b0}},
      '{OP_NORMALIZE, 2'd3, 10'd1023, 1'b0, '0},
      '{OP_NORMALIZE, 2'd3, 10'd0,    1'b0, '0},
      '{OP_CALIBRATE, 2'd3, 10'd682,  1'b1, '{10'd682,  1'b0, 1'b0}},
      '{OP_NORMALIZE, 2'd3, 10'd341,  1'b0, '0}
   };

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Advances the learned ranges and returns the reading the block should give.
   function automatic reading_type calibrate_or_normalize(op_type op, int unsigned ch,
                                                           int unsigned s);
      reading_type r;
      int unsigned lo, hi, q;
      r = '0;
      if (op == OP_CALIBRATE) begin
         if (s < learned_min[ch]) learned_min[ch] = s;
         if (s > learned_max[ch]) learned_max[ch] = s;
         r.value = sample_type'(s);
         return r;
      end
      lo = learned_min[ch];
      hi = learned_max[ch];
      if (hi < lo) begin
         r.uncalibrated = 1'b1;
         return r;
      end
      if (s < lo) s = lo;
      if (s > hi) s = hi;
      q = ((s - lo) * 1023) / (hi - lo + 1);
      r.value = sample_type'(q);
      r.out_of_limits = (q < limit_low) || (q > limit_high);
      return r;
   endfunction

   task automatic send_sample(op_type op, logic [1:0] ch, sample_type s,
                              logic fixed, reading_type want);
      int          gap;
      reading_type r;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {6'b0, s};
      req_tuser  = {ch, op};
      do @(posedge clock); while (!req_tready);
      r = calibrate_or_normalize(op, 32'(ch), 32'(s));
      if (fixed) r = want;
      readings_due.push_back(r);
      if (op == OP_CALIBRATE) n_cal++;
      else n_norm++;
   endtask

   // Holds the input side until every reading has come back.
   task automatic drain_readings();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_limit(reg_index_type idx, sample_type val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_FAULT_LOW) limit_low = 32'(val);
      else limit_high = 32'(val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // receiver stall pattern cycles through four styles
   always @(negedge clock) begin
      rx_tick++;
      case (rx_tick[8:7])
         2'd0: rsp_tready = 1'b1;
         2'd1: rsp_tready = 1'($urandom_range(0, 1));
         2'd2: rsp_tready = (rx_tick[2:0] == 3'd0);
         default: rsp_tready = ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (readings_due.size() == 0) begin
            $error("unexpected result transfer: value %0d", rsp_tdata[9:0]);
            fail_count++;
         end else begin
            want = readings_due.pop_front();
            checked++;
            if (rsp_tuser[0]) n_flagged++;
            if (rsp_tuser[1]) n_uncal++;
            if (rsp_tdata[9:0] !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, rsp_tdata[9:0]);
               fail_count++;
            end
            if (rsp_tuser[0] !== want.out_of_limits) begin
               $error("out_of_limits: expected %0d, got %0d", want.out_of_limits,
                      rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tuser[1] !== want.uncalibrated) begin
               $error("uncalibrated: expected %0d, got %0d", want.uncalibrated,
                      rsp_tuser[1]);
               fail_count++;
            end
            if (rsp_tdata[15:10] !== 6'b0) begin
               $error("tdata pad: expected 0, got %0d", rsp_tdata[15:10]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int unsigned lows  [N_PHASES];
      int unsigned highs [N_PHASES];
      int          gaps  [N_PHASES];
      int unsigned lo, hi, s;
      int          ch;
      op_type      op;

      for (int i = 0; i < CHANNELS; i++) begin
         learned_min[i] = 1023;
         learned_max[i] = 0;
      end
      lows  = '{0, 1023, $urandom_range(0, 1023), 512, 100};
      highs = '{1023, 0, $urandom_range(0, 1023), 512, 900};
      gaps  = '{6, 0, 12, 30, 3};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      gap_max = 4;
      foreach (directed_rows[i])
         send_sample(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].s,
                     directed_rows[i].fixed, directed_rows[i].want);

      for (int p = 0; p < N_PHASES; p++) begin
         drain_readings();
         // order of the two writes alternates between phases
         if (p[0]) begin
            write_limit(REG_FAULT_HIGH, sample_type'(highs[p]));
            write_limit(REG_FAULT_LOW, sample_type'(lows[p]));
         end else begin
            write_limit(REG_FAULT_LOW, sample_type'(lows[p]));
            write_limit(REG_FAULT_HIGH, sample_type'(highs[p]));
         end
         gap_max = gaps[p];
         burst_left = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            ch = $urandom_range(0, 3);
            op = ($urandom_range(0, 9) < 3) ? OP_CALIBRATE : OP_NORMALIZE;
            lo = learned_min[ch];
            hi = learned_max[ch];
            s  = $urandom_range(0, 1023);
            // keep most samples near the learned range so it widens slowly
            if (hi >= lo) begin
               if (op == OP_CALIBRATE && $urandom_range(0, 19) != 0)
                  s = $urandom_range((lo < 6) ? 0 : lo - 6, (hi > 1017) ? 1023 : hi + 6);
               else if (op == OP_NORMALIZE && $urandom_range(0, 4) != 0)
                  s = $urandom_range((lo < 20) ? 0 : lo - 20,
                                     (hi > 1003) ? 1023 : hi + 20);
            end
            send_sample(op, 2'(ch), sample_type'(s), 1'b0, '0);
         end
      end

      drain_readings();
      $display("Covered %0d calibrate and %0d normalize transfers over %0d limit settings;",
               n_cal, n_norm, N_PHASES);
      $display("%0d results checked, %0d flagged out of limits, %0d uncalibrated.",
               checked, n_flagged, n_uncal);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
